>>> rtl/rna_pkg.sv
// Shared codes and types for the rational number ALU.
package rna_pkg;

	// Operation select codes
	localparam logic [2:0] FN_ADD  = 3'd0;
	localparam logic [2:0] FN_SUB  = 3'd1;
	localparam logic [2:0] FN_MUL  = 3'd2;
	localparam logic [2:0] FN_DIV  = 3'd3;
	localparam logic [2:0] FN_SIMP = 3'd4;
	localparam logic [2:0] FN_NORM = 3'd5;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// Micro-operations of the shared unit
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1,
		OP_GCD = 2'd2,
		OP_END = 2'd3
	} uop_t;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ISSUE = 5'b00010,
		S_RUN   = 5'b00100,
		S_WB    = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

endpackage

>>> rtl/rational_number_alu.sv
// Rational number ALU: sequencer around one shared shift/add/subtract unit.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | func, a_num, a_den, b_num, b_den, target_den
// out     | output    | out_valid / out_stall | res_num, res_den, status
//
// One transaction at a time. Each multiply or divide pass on the shared unit
// handles one bit per cycle between an issue step and a write-back step; the
// binary gcd pass runs until both operands are odd and equal. mul/div: 2 passes,
// simplify: gcd + 2 passes, normalize: 2 passes, add/sub: gcd + 5 passes.
// Errors found at accept skip every pass. Reset clears the sequencer only.
// A waiting result sits in the output register while the next input is taken.
module rational_number_alu #(
	parameter int WORD_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [63:0] a_num,
	input  logic signed [63:0] a_den,
	input  logic signed [63:0] b_num,
	input  logic signed [63:0] b_den,
	input  logic signed [63:0] target_den,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] res_num,
	output logic signed [63:0] res_den,
	output logic [1:0]         status
);
	import rna_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(W);
	localparam logic [W-1:0] TOP = {1'b1, {(W-1){1'b0}}};
	localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [W-1:0] with_sign(input logic neg, input logic [W-1:0] m);
		return neg ? (~m + 1'b1) : m;
	endfunction

	state_t           state_q;
	logic [2:0]       step_q;
	logic [CW-1:0]    cnt_q;
	logic             out_valid_q;

	logic [2:0]       func_q;
	logic [W-1:0]     an_q, ad_q, bn_q, bd_q;
	logic [W-1:0]     g_q, qa_q, qb_q, rn_q, rd_q, p2_q;
	logic             ovf_q;
	logic [1:0]       st_q;
	uop_t             op_q;
	logic             neg_q, chk_q;
	logic [W-1:0]     hi_q, lo_q, b_q;
	logic [CW-1:0]    k_q;
	logic signed [W-1:0] res_num_q, res_den_q;
	logic [1:0]       status_q;

	// Input word slices
	logic [W-1:0] an_w, ad_w, bn_w, bd_w, td_w;
	assign an_w = a_num[W-1:0];
	assign ad_w = a_den[W-1:0];
	assign bn_w = b_num[W-1:0];
	assign bd_w = b_den[W-1:0];
	assign td_w = target_den[W-1:0];

	// Early outcomes decided at accept
	logic in_take, zero_den, div_zero, simp_zero, early;
	assign in_take   = (state_q == S_IDLE) && in_valid;
	assign zero_den  = (func > FN_NORM) || (ad_w == '0)
		|| ((func <= FN_DIV) && (bd_w == '0))
		|| ((func == FN_NORM) && (td_w == '0));
	assign div_zero  = (func == FN_DIV) && (bn_w == '0);
	assign simp_zero = (func == FN_SIMP) && (an_w == '0);
	assign early     = zero_den || div_zero || simp_zero;

	// Microprogram: next pass for the current operation and step
	uop_t         iss_op;
	logic [W-1:0] iss_x, iss_y;
	logic         iss_neg, iss_chk, iss_ovf;
	always_comb begin
		iss_op  = OP_END;
		iss_x   = '0;
		iss_y   = '0;
		iss_neg = 1'b0;
		iss_chk = 1'b0;
		iss_ovf = 1'b0;
		unique case (func_q)
			FN_ADD, FN_SUB: begin
				unique case (step_q)
					3'd0: begin
						iss_op = OP_GCD; iss_x = mag(ad_q); iss_y = mag(bd_q);
					end
					3'd1: begin
						iss_op = OP_DIV; iss_x = mag(ad_q); iss_y = g_q;
					end
					3'd2: begin
						iss_op = OP_DIV; iss_x = mag(bd_q); iss_y = g_q;
					end
					3'd3: begin
						iss_op = OP_MUL; iss_x = qa_q; iss_y = mag(bd_q);
					end
					3'd4: begin
						iss_op  = OP_MUL; iss_x = mag(an_q); iss_y = qb_q;
						iss_neg = an_q[W-1] ^ (ad_q[W-1] | (qb_q == TOP));
						iss_ovf = (qb_q == TOP) && !ad_q[W-1];
					end
					3'd5: begin
						iss_op  = OP_MUL; iss_x = mag(bn_q); iss_y = qa_q;
						iss_neg = bn_q[W-1] ^ (bd_q[W-1] | (qa_q == TOP));
						iss_ovf = (qa_q == TOP) && !bd_q[W-1];
					end
					default: iss_op = OP_END;
				endcase
			end
			FN_MUL: begin
				unique case (step_q)
					3'd0: begin
						iss_op = OP_MUL; iss_x = mag(an_q); iss_y = mag(bn_q);
						iss_neg = an_q[W-1] ^ bn_q[W-1];
					end
					3'd1: begin
						iss_op = OP_MUL; iss_x = mag(ad_q); iss_y = mag(bd_q);
						iss_neg = ad_q[W-1] ^ bd_q[W-1];
					end
					default: iss_op = OP_END;
				endcase
			end
			FN_DIV: begin
				unique case (step_q)
					3'd0: begin
						iss_op = OP_MUL; iss_x = mag(an_q); iss_y = mag(bd_q);
						iss_neg = an_q[W-1] ^ bd_q[W-1];
					end
					3'd1: begin
						iss_op = OP_MUL; iss_x = mag(ad_q); iss_y = mag(bn_q);
						iss_neg = ad_q[W-1] ^ bn_q[W-1];
					end
					default: iss_op = OP_END;
				endcase
			end
			FN_SIMP: begin
				unique case (step_q)
					3'd0: begin
						iss_op = OP_GCD; iss_x = mag(an_q); iss_y = mag(ad_q);
					end
					3'd1: begin
						iss_op = OP_DIV; iss_x = mag(an_q); iss_y = g_q;
						iss_neg = an_q[W-1];
					end
					3'd2: begin
						iss_op = OP_DIV; iss_x = mag(ad_q); iss_y = g_q;
						iss_neg = ad_q[W-1];
					end
					default: iss_op = OP_END;
				endcase
			end
			default: begin
				unique case (step_q)
					3'd0: begin
						iss_op = OP_MUL; iss_x = mag(an_q); iss_y = mag(rd_q);
						iss_neg = an_q[W-1] ^ rd_q[W-1];
					end
					3'd1: begin
						iss_op = OP_DIV; iss_x = mag(p2_q); iss_y = mag(ad_q);
						iss_neg = p2_q[W-1] ^ ad_q[W-1];
						iss_chk = 1'b1;
					end
					default: iss_op = OP_END;
				endcase
			end
		endcase
	end

	// Final sum for add/sub
	logic [W-1:0] sum_w;
	logic         sum_ovf;
	assign sum_w   = rn_q + p2_q;
	assign sum_ovf = (rn_q[W-1] == p2_q[W-1]) && (sum_w[W-1] != rn_q[W-1]);

	// Shared adder/subtractor
	logic [W:0]   alu_x, alu_y;
	logic         alu_sub;
	logic [W+1:0] alu_r;
	logic         alu_ge, alu_eq;
	always_comb begin
		unique case (op_q)
			OP_MUL: begin
				alu_x = {1'b0, hi_q}; alu_y = {1'b0, lo_q[0] ? b_q : '0}; alu_sub = 1'b0;
			end
			OP_DIV: begin
				alu_x = {hi_q, lo_q[W-1]}; alu_y = {1'b0, b_q}; alu_sub = 1'b1;
			end
			default: begin
				alu_x = {1'b0, hi_q}; alu_y = {1'b0, b_q}; alu_sub = 1'b1;
			end
		endcase
		alu_r = {1'b0, alu_x} + {1'b0, alu_sub ? ~alu_y : alu_y} + (W+2)'(alu_sub);
	end
	assign alu_ge = alu_r[W+1];
	assign alu_eq = (alu_r[W:0] == '0);

	// Pass completion
	logic both_odd, run_last;
	assign both_odd = hi_q[0] && b_q[0];
	assign run_last = (op_q == OP_GCD) ? (both_odd && alu_eq) : (cnt_q == '0);

	// Write-back value and overflow of a multiply or divide pass
	logic [W-1:0] wb_val;
	logic         fit_lo, wb_ovf;
	assign wb_val = with_sign(neg_q, lo_q);
	assign fit_lo = (lo_q < TOP) || (neg_q && (lo_q == TOP));
	assign wb_ovf = (op_q == OP_MUL) ? !((hi_q == '0) && fit_lo) : (chk_q && !fit_lo);

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= early ? S_DONE : S_ISSUE;
						step_q  <= '0;
					end
				end
				S_ISSUE: begin
					state_q <= (iss_op == OP_END) ? S_DONE : S_RUN;
					cnt_q   <= CNT_LAST;
				end
				S_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (run_last) state_q <= S_WB;
				end
				S_WB: begin
					step_q  <= step_q + 1'b1;
					state_q <= S_ISSUE;
				end
				default: begin
					if (out_load) state_q <= S_IDLE;
				end
			endcase
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q <= func;
			an_q   <= an_w;
			ad_q   <= ad_w;
			bd_q   <= bd_w;
			bn_q   <= (func == FN_SUB) ? (~bn_w + 1'b1) : bn_w;
			ovf_q  <= (func == FN_SUB) && (bn_w == TOP);
			rn_q   <= '0;
			priority if (zero_den) begin
				st_q <= ST_ZERO_DEN;
				rd_q <= '0;
			end else if (div_zero) begin
				st_q <= ST_DIV_ZERO;
				rd_q <= '0;
			end else if (simp_zero) begin
				st_q <= ST_OK;
				rd_q <= W'(1);
			end else begin
				st_q <= ST_OK;
				rd_q <= td_w;
			end
		end
		if (state_q == S_ISSUE) begin
			if (iss_op == OP_END) begin
				if (func_q == FN_ADD || func_q == FN_SUB) begin
					rn_q  <= sum_w;
					ovf_q <= ovf_q | sum_ovf;
				end
			end else begin
				op_q  <= iss_op;
				neg_q <= iss_neg;
				chk_q <= iss_chk;
				ovf_q <= ovf_q | iss_ovf;
				k_q   <= '0;
				b_q   <= iss_y;
				if (iss_op == OP_GCD) begin
					hi_q <= iss_x;
				end else begin
					hi_q <= '0;
					lo_q <= iss_x;
				end
			end
		end
		// One step of the shared unit
		if (state_q == S_RUN) begin
			unique case (op_q)
				OP_MUL: begin
					hi_q <= alu_r[W:1];
					lo_q <= {alu_r[0], lo_q[W-1:1]};
				end
				OP_DIV: begin
					hi_q <= alu_ge ? alu_r[W-1:0] : {hi_q[W-2:0], lo_q[W-1]};
					lo_q <= {lo_q[W-2:0], alu_ge};
				end
				default: begin
					priority if (!hi_q[0] && !b_q[0]) begin
						hi_q <= hi_q >> 1;
						b_q  <= b_q >> 1;
						k_q  <= k_q + 1'b1;
					end else if (!hi_q[0]) begin
						hi_q <= hi_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (alu_eq) begin
						hi_q <= hi_q;
					end else if (alu_ge) begin
						hi_q <= alu_r[W-1:0];
					end else begin
						hi_q <= b_q;
						b_q  <= hi_q;
					end
				end
			endcase
		end
		// Store the pass result
		if (state_q == S_WB) begin
			if (op_q == OP_GCD) begin
				g_q <= hi_q << k_q;
			end else begin
				ovf_q <= ovf_q | wb_ovf;
				unique case (func_q)
					FN_ADD, FN_SUB: begin
						unique case (step_q)
							3'd1:    qa_q <= wb_val;
							3'd2:    qb_q <= wb_val;
							3'd3:    rd_q <= wb_val;
							3'd4:    rn_q <= wb_val;
							default: p2_q <= wb_val;
						endcase
					end
					FN_MUL, FN_DIV: begin
						if (step_q == 3'd0) rn_q <= wb_val;
						else rd_q <= wb_val;
					end
					FN_SIMP: begin
						if (step_q == 3'd1) rn_q <= wb_val;
						else rd_q <= wb_val;
					end
					default: begin
						if (step_q == 3'd0) p2_q <= wb_val;
						else rn_q <= wb_val;
					end
				endcase
			end
		end
		if (out_load) begin
			res_num_q <= rn_q;
			res_den_q <= rd_q;
			status_q  <= ((st_q == ST_OK) && ovf_q) ? ST_OVERFLOW : st_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign res_num   = 64'(res_num_q);
	assign res_den   = 64'(res_den_q);
	assign status    = status_q;

`ifndef SYNTHESIS
	// Error results carry zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ZERO_DEN || status == ST_DIV_ZERO)
		|-> (res_num == 64'd0) && (res_den == 64'd0))
		else $error("error result with nonzero fields");
	// Gcd pass never sees a zero operand
	a_gcd_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && (op_q == OP_GCD) |-> (hi_q != '0) && (b_q != '0))
		else $error("gcd operand is zero");
	// Divide pass never has a zero divisor
	a_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && (op_q == OP_DIV) |-> (b_q != '0))
		else $error("divide by zero in shared unit");
	// Microprogram step stays in range
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |-> (step_q <= 3'd6))
		else $error("step counter out of range");
`endif

endmodule

>>> test/rational_number_alu_checker.sv
// Checker for the rational number ALU: predicts each result and compares it.
module rational_number_alu_checker
	import rna_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [63:0] a_num,
	input  logic signed [63:0] a_den,
	input  logic signed [63:0] b_num,
	input  logic signed [63:0] b_den,
	input  logic signed [63:0] target_den,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [63:0] res_num,
	input  logic signed [63:0] res_den,
	input  logic [1:0]         status,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] TOP_MAG = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [63:0] num;
		logic [63:0] den;
		logic [1:0]  st;
	} rat_result_t;

	rat_result_t expected_results[$];

	function automatic logic is_neg(logic [63:0] v);
		return v[63];
	endfunction

	function automatic logic [63:0] mag_of(logic [63:0] v);
		return v[63] ? 64'd0 - v : v;
	endfunction

	function automatic logic fits(logic neg, logic [63:0] m);
		return (m < TOP_MAG) || (neg && m == TOP_MAG);
	endfunction

	function automatic logic [63:0] signed_mag(logic neg, logic [63:0] m);
		return neg ? 64'd0 - m : m;
	endfunction

	// exact product of magnitudes must fit 64 bits, then the signed range
	function automatic logic prod_fits(logic [63:0] x, logic [63:0] y);
		logic [127:0] p;
		p = mag_of(x) * mag_of(y);
		if (p == 0)
			return 1'b1;
		if (p[127:64] != 0)
			return 1'b0;
		return fits(is_neg(x) != is_neg(y), p[63:0]);
	endfunction

	function automatic logic [63:0] gcd_of(logic [63:0] u, logic [63:0] v);
		logic [63:0] t;
		while (v != 0) begin
			t = u % v;
			u = v;
			v = t;
		end
		return u;
	endfunction

	function automatic rat_result_t predict_rational(logic [2:0] fn, logic [63:0] an,
			logic [63:0] ad, logic [63:0] bn, logic [63:0] bd, logic [63:0] td);
		rat_result_t r;
		logic ovf;
		logic [63:0] ma, mb, g, qa, qb, fa, fb, p1, p2, s, p, q;
		logic [127:0] wide;
		logic neg;
		r = '0;
		ovf = 1'b0;
		if (fn > FN_NORM) begin
			r.st = ST_ZERO_DEN;
		end else if (ad == 0 || (fn <= FN_DIV && bd == 0) || (fn == FN_NORM && td == 0)) begin
			r.st = ST_ZERO_DEN;
		end else if (fn == FN_DIV && bn == 0) begin
			r.st = ST_DIV_ZERO;
		end else if (fn == FN_ADD || fn == FN_SUB) begin
			if (fn == FN_SUB) begin
				if (bn == TOP_MAG)
					ovf = 1'b1;
				bn = 64'd0 - bn;
			end
			ma = mag_of(ad);
			mb = mag_of(bd);
			g = gcd_of(ma, mb);
			qa = ma / g;
			qb = mb / g;
			wide = qa * mb;
			if (wide[127:64] != 0 || !fits(1'b0, wide[63:0]))
				ovf = 1'b1;
			r.den = wide[63:0];
			if (!fits(is_neg(ad), qb) || !fits(is_neg(bd), qa))
				ovf = 1'b1;
			fa = signed_mag(is_neg(ad), qb);
			fb = signed_mag(is_neg(bd), qa);
			if (!prod_fits(an, fa) || !prod_fits(bn, fb))
				ovf = 1'b1;
			p1 = an * fa;
			p2 = bn * fb;
			s = p1 + p2;
			if (p1[63] == p2[63] && s[63] != p1[63])
				ovf = 1'b1;
			r.num = s;
		end else if (fn == FN_MUL) begin
			ovf = !prod_fits(an, bn) || !prod_fits(ad, bd);
			r.num = an * bn;
			r.den = ad * bd;
		end else if (fn == FN_DIV) begin
			ovf = !prod_fits(an, bd) || !prod_fits(ad, bn);
			r.num = an * bd;
			r.den = ad * bn;
		end else if (fn == FN_SIMP) begin
			if (an == 0) begin
				r.num = 64'd0;
				r.den = 64'd1;
			end else begin
				g = gcd_of(mag_of(an), mag_of(ad));
				r.num = signed_mag(is_neg(an), mag_of(an) / g);
				r.den = signed_mag(is_neg(ad), mag_of(ad) / g);
			end
		end else begin
			p = an * td;
			neg = is_neg(p) != is_neg(ad);
			q = mag_of(p) / mag_of(ad);
			ovf = !prod_fits(an, td) || !fits(neg, q);
			r.num = signed_mag(neg, q);
			r.den = td;
		end
		if (r.st == ST_OK && ovf)
			r.st = ST_OVERFLOW;
		if (r.st == ST_ZERO_DEN || r.st == ST_DIV_ZERO) begin
			r.num = '0;
			r.den = '0;
		end
		return r;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		rat_result_t exp_r;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_rational(func, a_num, a_den,
					b_num, b_den, target_den));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction");
					errs++;
				end else begin
					exp_r = expected_results.pop_front();
					if (res_num !== exp_r.num) begin
						$error("res_num expected %h actual %h", exp_r.num, res_num);
						errs++;
					end
					if (res_den !== exp_r.den) begin
						$error("res_den expected %h actual %h", exp_r.den, res_den);
						errs++;
					end
					if (status !== exp_r.st) begin
						$error("status expected %0d actual %0d", exp_r.st, status);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending    <= expected_results.size();
		end
	end
endmodule

>>> test/tb_rational_number_alu.sv
// Testbench top for the rational number ALU: stimulus, stalls and verdict.
module tb_rational_number_alu;
	import rna_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 4_000_000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         func;
	logic signed [63:0] a_num, a_den, b_num, b_den, target_den;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] res_num, res_den;
	logic [1:0]         status;
	int                 fail_count;
	int                 pending;
	int                 cycle_count;
	logic               quiet_phase;
	logic               hold_off_done;

	rational_number_alu dut (.*);

	rational_number_alu_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// random operand: mix of edges, small values and full range
	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'd0;
			3: return 64'hffff_ffff_ffff_ffff;
			4, 5: return 64'($signed($urandom_range(0, 200)) - 100);
			6: return {{32{1'b0}}, $urandom()};
			7: return 64'($signed($urandom()));
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// one input transaction, held until accepted
	task automatic send_item(logic [2:0] fn, logic [63:0] an, logic [63:0] ad,
			logic [63:0] bn, logic [63:0] bd, logic [63:0] td);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		func       <= fn;
		a_num      <= an;
		a_den      <= ad;
		b_num      <= bn;
		b_den      <= bd;
		target_den <= td;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls, one long hold-off first
	initial begin
		int gap;
		out_stall = 1'b0;
		hold_off_done = 1'b0;
		wait (arst_n);
		@(negedge clk);
		out_stall <= 1'b1;
		repeat (2000) @(negedge clk);
		out_stall <= 1'b0;
		hold_off_done = 1'b1;
		forever begin
			@(negedge clk);
			if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 6);
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [2:0] fn;
		in_valid    = 1'b0;
		func        = FN_ADD;
		a_num       = '0;
		a_den       = '0;
		b_num       = '0;
		b_den       = '0;
		target_den  = '0;
		quiet_phase = 1'b0;
		arst_n      = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: each operation, extremes, error cases
		send_item(FN_ADD, 64'sd1, 64'sd2, 64'sd1, 64'sd3, 64'sd0);
		send_item(FN_SUB, 64'sd1, -64'sd4, 64'h8000_0000_0000_0000, 64'sd6, 64'sd0);
		send_item(FN_MUL, 64'sd3, 64'sd5, -64'sd7, 64'sd11, 64'sd0);
		send_item(FN_DIV, 64'sd3, 64'sd5, -64'sd7, 64'sd11, 64'sd0);
		send_item(FN_DIV, 64'sd3, 64'sd5, 64'sd0, 64'sd11, 64'sd0);
		send_item(FN_SIMP, -64'sd12, 64'sd18, 64'sd0, 64'sd0, 64'sd0);
		send_item(FN_SIMP, 64'sd0, -64'sd18, 64'sd0, 64'sd0, 64'sd0);
		send_item(FN_NORM, 64'sd7, 64'sd3, 64'sd0, 64'sd0, 64'sd10);
		send_item(FN_NORM, -64'sd7, 64'sd3, 64'sd0, 64'sd0, 64'sd0);
		send_item(FN_ADD, 64'sd1, 64'sd0, 64'sd1, 64'sd3, 64'sd0);
		send_item(FN_MUL, 64'sd1, 64'sd2, 64'sd1, 64'sd0, 64'sd0);
		send_item(3'd6, 64'sd1, 64'sd2, 64'sd3, 64'sd4, 64'sd5);
		send_item(3'd7, 64'sd1, 64'sd2, 64'sd3, 64'sd4, 64'sd5);
		send_item(FN_MUL, 64'h7fff_ffff_ffff_ffff, 64'sd1, 64'sd2, 64'sd1, 64'sd0);
		send_item(FN_ADD, 64'h7fff_ffff_ffff_ffff, 64'sd1, 64'h7fff_ffff_ffff_ffff,
			64'sd1, 64'sd0);
		send_item(FN_ADD, 64'sd1, 64'h8000_0000_0000_0000, 64'sd1, 64'sd3, 64'sd0);
		send_item(FN_SIMP, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 0, 0, 0);
		send_item(FN_NORM, 64'h8000_0000_0000_0000, -64'sd1, 0, 0, 64'sd1);
		send_item(FN_DIV, 64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
			64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 64'sd0);

		// random part; the last stretch runs without idling
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > RANDOM_ITEMS - 150 && hold_off_done)
				quiet_phase = 1'b1;
			fn = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			send_item(fn, rand_word(), rand_word(), rand_word(), rand_word(),
				rand_word());
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (1500) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
